@@ design/fct_pkg.sv @@
`default_nettype none
package fct_pkg;

	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int REG_COUNT = 6;
	localparam int FRAC_BITS = 14;
	localparam int EXT_W     = 15;
	localparam int NORM_W    = 16;

	localparam logic [1:0] FUNC_POINT  = 2'd0;
	localparam logic [1:0] FUNC_SPHERE = 2'd1;
	localparam logic [1:0] FUNC_BOX    = 2'd2;

	localparam logic [1:0] V_OUT   = 2'd0;
	localparam logic [1:0] V_CROSS = 2'd1;
	localparam logic [1:0] V_IN    = 2'd2;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} fct_adv_t;

	typedef struct packed {
		logic neg;
		logic sph_out;
		logic sph_cross;
		logic box_none;
		logic box_all;
	} fct_flags_t;

endpackage
`default_nettype wire

@@ design/fct_lane.sv @@
`default_nettype none
module fct_lane
	import fct_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire fct_adv_t                       en,
	input  wire logic [CFG_W-1:0]               plane,
	input  wire logic signed [COORD_WIDTH-1:0]  pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]  pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]  pos_z,
	input  wire logic [EXT_W-1:0]               ext_x,
	input  wire logic [EXT_W-1:0]               ext_y,
	input  wire logic [EXT_W-1:0]               ext_z,
	input  wire logic [EXT_W-1:0]               radius_s2,
	output fct_flags_t                          flags_s3
);

	localparam int PW  = NORM_W + COORD_WIDTH;
	localparam int DW  = ((PW > 30) ? PW : 30) + 2;
	localparam int TW  = 2 * NORM_W;
	localparam int CWD = ((DW > TW) ? DW : TW) + 2;

	logic signed [NORM_W-1:0] nx, ny, nz, off;

	logic signed [PW-1:0]     px_s1, py_s1, pz_s1;
	logic signed [TW-1:0]     tx_s1, ty_s1, tz_s1;
	logic signed [NORM_W-1:0] off_s1;

	logic signed [DW-1:0]     dist_s2;
	logic signed [TW-1:0]     tx_s2, ty_s2, tz_s2;

	logic signed [CWD-1:0]    distw, radv;
	logic [7:0]               front;
	fct_flags_t               flags;

	assign nx  = plane[15:0];
	assign ny  = plane[31:16];
	assign nz  = plane[47:32];
	assign off = plane[63:48];

	always_ff @(posedge clk) begin
		if (en.s1) begin
			px_s1  <= nx * pos_x;
			py_s1  <= ny * pos_y;
			pz_s1  <= nz * pos_z;
			tx_s1  <= nx * $signed({1'b0, ext_x});
			ty_s1  <= ny * $signed({1'b0, ext_y});
			tz_s1  <= nz * $signed({1'b0, ext_z});
			off_s1 <= off;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			dist_s2 <= DW'(px_s1) + DW'(py_s1) + DW'(pz_s1) + (DW'(off_s1) <<< FRAC_BITS);
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			tz_s2   <= tz_s1;
		end
	end

	assign distw = CWD'(dist_s2);
	assign radv  = CWD'($signed({1'b0, radius_s2, {FRAC_BITS{1'b0}}}));

	always_comb begin
		logic signed [CWD-1:0] cx, cy, cz, corner;
		for (int c = 0; c < 8; c++) begin
			cx = c[0] ? -CWD'(tx_s2) : CWD'(tx_s2);
			cy = c[1] ? -CWD'(ty_s2) : CWD'(ty_s2);
			cz = c[2] ? -CWD'(tz_s2) : CWD'(tz_s2);
			corner = distw + cx + cy + cz;
			front[c] = !corner[CWD-1];
		end
	end

	always_comb begin
		flags.neg       = distw[CWD-1];
		flags.sph_out   = distw < -radv;
		flags.sph_cross = (distw < radv) && (distw > -radv);
		flags.box_none  = (front == 8'h00);
		flags.box_all   = (front == 8'hff);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			flags_s3 <= flags;
		end
	end

endmodule
`default_nettype wire

@@ design/frustum_cull_test_top.sv @@
// Frustum cull test: classifies points, spheres and axis-aligned boxes
// against PLANE_COUNT planes held in configuration registers.
// Configuration: wr_en/wr_idx/wr_data write plane register wr_idx (0 left,
// 1 right, 2 bottom, 3 top, 4 near, 5 far); other indexes are ignored.
// Write only while no query is in flight.
// Input word: func, pos_x/y/z, radius, ext_x/y/z on in_valid/in_ready.
// Output word: verdict (0 outside, 1 crossing, 2 inside) on
// out_valid/out_ready.
// Pipeline: the accepting edge loads the first of four register stages
// (multiply, plane sum, corner and sphere compare, cross-plane reduce into
// the output register); out_valid is that register's valid. Throughput: one
// word per cycle while out_ready does not stall, set by the four-stage
// pipeline with one multiplier set per plane.
// Reset clears all planes to zero and empties the pipeline.
// A stall on out_ready holds the output word; a stage holds only while the
// next is full and held, so in_ready falls only with all four stages full.
`default_nettype none
module frustum_cull_test_top
	import fct_pkg::*;
#(
	parameter int PLANE_COUNT = 6,
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [CFG_IDX_W-1:0]           wr_idx,
	input  wire logic [CFG_W-1:0]               wr_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     func,
	input  wire logic signed [COORD_WIDTH-1:0]  pos_x,
	input  wire logic signed [COORD_WIDTH-1:0]  pos_y,
	input  wire logic signed [COORD_WIDTH-1:0]  pos_z,
	input  wire logic [EXT_W-1:0]               radius,
	input  wire logic [EXT_W-1:0]               ext_x,
	input  wire logic [EXT_W-1:0]               ext_y,
	input  wire logic [EXT_W-1:0]               ext_z,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          verdict
);

	logic [CFG_W-1:0] plane_q [PLANE_COUNT];

	logic             v_s1, v_s2, v_s3, v_s4;
	logic             rdy1, rdy2, rdy3, rdy4;
	fct_adv_t         en;
	logic [1:0]       func_s1, func_s2, func_s3;
	logic [EXT_W-1:0] radius_s1, radius_s2;
	logic [1:0]       verdict_s4;
	logic [1:0]       verdict_d;
	fct_flags_t       flags_s3 [PLANE_COUNT];

	for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				plane_q[k] <= '0;
			end else if (wr_en && (wr_idx == CFG_IDX_W'(k)) && (k < REG_COUNT)) begin
				plane_q[k] <= wr_data;
			end
		end

		fct_lane #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_lane (
			.clk      (clk),
			.en       (en),
			.plane    (plane_q[k]),
			.pos_x    (pos_x),
			.pos_y    (pos_y),
			.pos_z    (pos_z),
			.ext_x    (ext_x),
			.ext_y    (ext_y),
			.ext_z    (ext_z),
			.radius_s2(radius_s2),
			.flags_s3 (flags_s3[k])
		);
	end

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign en.s1    = rdy1;
	assign en.s2    = rdy2;
	assign en.s3    = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			func_s1   <= func;
			radius_s1 <= radius;
		end
		if (rdy2) begin
			func_s2   <= func_s1;
			radius_s2 <= radius_s1;
		end
		if (rdy3) begin
			func_s3 <= func_s2;
		end
		if (rdy4) begin
			verdict_s4 <= verdict_d;
		end
	end

	always_comb begin
		logic any_neg, any_out, any_cross, any_none, all_full;
		any_neg   = 1'b0;
		any_out   = 1'b0;
		any_cross = 1'b0;
		any_none  = 1'b0;
		all_full  = 1'b1;
		for (int k = 0; k < PLANE_COUNT; k++) begin
			any_neg   = any_neg   | flags_s3[k].neg;
			any_out   = any_out   | flags_s3[k].sph_out;
			any_cross = any_cross | flags_s3[k].sph_cross;
			any_none  = any_none  | flags_s3[k].box_none;
			all_full  = all_full  & flags_s3[k].box_all;
		end
		unique case (func_s3)
			FUNC_POINT:  verdict_d = any_neg ? V_OUT : V_IN;
			FUNC_SPHERE: verdict_d = any_out ? V_OUT : (any_cross ? V_CROSS : V_IN);
			FUNC_BOX:    verdict_d = any_none ? V_OUT : (all_full ? V_IN : V_CROSS);
			default:     verdict_d = V_OUT;
		endcase
	end

	assign out_valid = v_s4;
	assign verdict   = verdict_s4;

`ifndef ASSERT_OFF
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted word did not reach stage one");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && !out_ready)
		else $error("input stalled with a free pipeline stage");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == V_OUT || verdict == V_CROSS || verdict == V_IN))
		else $error("illegal verdict code");
`endif

endmodule
`default_nettype wire
